// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker unit, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hdl/luhn_chk_pkg.sv =====
package luhn_chk_pkg;

  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int COUNT_W   = 5;
  localparam int LEN_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int ISSUER_W  = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 4'd1;

  localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 5'd13;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 5'd19;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

  // Leading digits of the issuer classes
  localparam logic [DIGIT_W-1:0] LEAD_AMEX_JCB = 4'd3;
  localparam logic [DIGIT_W-1:0] LEAD_VISA     = 4'd4;
  localparam logic [DIGIT_W-1:0] LEAD_MC       = 4'd5;
  localparam logic [DIGIT_W-1:0] LEAD_MAESTRO  = 4'd6;
  localparam logic [DIGIT_W-1:0] AMEX_SECOND_A = 4'd4;
  localparam logic [DIGIT_W-1:0] AMEX_SECOND_B = 4'd7;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID      = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_BAD_LENGTH = 2'd2,
    ST_LUHN_FAIL  = 2'd3
  } status_t;

  typedef enum logic [ISSUER_W-1:0] {
    ISS_AMEX    = 3'd0,
    ISS_JCB     = 3'd1,
    ISS_VISA    = 3'd2,
    ISS_MC      = 3'd3,
    ISS_MAESTRO = 3'd4,
    ISS_OTHER   = 3'd5
  } issuer_t;

  typedef struct packed {
    logic [LEN_W-1:0] min_length;
    logic [LEN_W-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic [DIGIT_W-1:0] sum_even;
    logic [DIGIT_W-1:0] sum_odd;
    logic               bad;
    logic [DIGIT_W-1:0] lead;
    logic [DIGIT_W-1:0] second;
    logic               parity;
  } acc_state_t;

  typedef struct packed {
    status_t            status;
    issuer_t            issuer;
    logic [COUNT_W-1:0] digit_count;
  } result_t;

  // Double a digit and fold it back to one digit
  function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] v;
    v = {d, 1'b0};
    return (v > 5'd9) ? DIGIT_W'(v - 5'd9) : v[DIGIT_W-1:0];
  endfunction

  // Add two decimal digits mod 10
  function automatic logic [DIGIT_W-1:0] mod10_add(input logic [DIGIT_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 5'd10) ? DIGIT_W'(s - 5'd10) : s[DIGIT_W-1:0];
  endfunction

endpackage

// ===== hdl/luhn_chk_if.sv =====
// Character channel
interface luhn_chk_char_if;
  logic                              valid;
  logic                              ready;
  logic [luhn_chk_pkg::CHAR_W-1:0]   char_code;
  logic                              is_last;

  modport source (output valid, char_code, is_last, input ready);
  modport sink   (input valid, char_code, is_last, output ready);
endinterface

// Result channel
interface luhn_chk_res_if;
  logic                              valid;
  logic                              ready;
  logic [luhn_chk_pkg::STATUS_W-1:0] status;
  logic [luhn_chk_pkg::ISSUER_W-1:0] issuer;
  logic [luhn_chk_pkg::COUNT_W-1:0]  digit_count;

  modport source (output valid, status, issuer, digit_count, input ready);
  modport sink   (input valid, status, issuer, digit_count, output ready);
endinterface

// Configuration write channel
interface luhn_chk_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [luhn_chk_pkg::CFG_IDX_W-1:0] index;
  logic [luhn_chk_pkg::LEN_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/card_number_luhn_checker_unit.sv =====
// Card number checker: Luhn mod-10 check, length limits and issuer class.
// chars   : one ASCII character per transaction, is_last marks the end of a
//           number. Space and codes 9 to 13 are skipped.
// results : one transaction per number (status, issuer, digit_count).
// cfg     : register writes, index 0 min_length, index 1 max_length; always
//           ready, other indexes are dropped. Write only while idle.
// Throughput: one character per cycle, except while a last character waits for
// a held result. The running sums and the digit counter update from the input
// register. The last character passes through the input register, then the
// result register, where the result is held until it is taken.
// Stall: a held result does not block characters of the next number; only a
// second last character waits in the input register until the result goes.
// Reset (rst, synchronous): clears the number state, the valid bits of the input
// and result registers, and sets min_length to 13 and max_length to 19.
`include "assert_macros.svh"

module card_number_luhn_checker_unit (
  input  logic            clk,
  input  logic            rst,
  luhn_chk_char_if.sink   chars,
  luhn_chk_res_if.source  results,
  luhn_chk_cfg_if.sink    cfg
);

  luhn_chk_pkg::cfg_t                regs;
  luhn_chk_pkg::acc_state_t          acc_state;
  luhn_chk_pkg::result_t             acc_res;
  luhn_chk_pkg::result_t             out_res;
  logic                              out_valid;
  logic                              s1_valid;
  logic [luhn_chk_pkg::CHAR_W-1:0]   s1_char;
  logic                              s1_last;
  logic                              s1_fire;

  luhn_chk_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // A non-last character always moves on; a last one needs a free result slot
  assign s1_fire     = s1_valid && (!s1_last || !out_valid || results.ready);
  assign chars.ready = !s1_valid || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char <= chars.char_code;
      s1_last <= chars.is_last;
    end
  end

  luhn_chk_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_fire),
    .char_code (s1_char),
    .is_last   (s1_last),
    .regs      (regs),
    .state     (acc_state),
    .res       (acc_res)
  );

  // Result register: load on a last character, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_res <= acc_res;
    end
  end

  assign results.valid       = out_valid;
  assign results.status      = out_res.status;
  assign results.issuer      = out_res.issuer;
  assign results.digit_count = out_res.digit_count;

  // Checks on the pipeline control
  `ASSERT_IMPLIES(a_mid_char_never_waits, clk, rst, s1_valid && !s1_last, s1_fire)
  `ASSERT_NEXT(a_last_gives_result, clk, rst, s1_fire && s1_last, results.valid)
  `ASSERT_NEXT(a_state_clear_after_last, clk, rst, s1_fire && s1_last, acc_state == '0)

endmodule

// ===== hdl/luhn_chk_cfg_regs.sv =====
module luhn_chk_cfg_regs (
  input  logic                 clk,
  input  logic                 rst,
  luhn_chk_cfg_if.sink         cfg,
  output luhn_chk_pkg::cfg_t   regs
);

  // Always take a write transaction
  assign cfg.ready = 1'b1;

  // Decode the index; drop writes past the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.min_length <= luhn_chk_pkg::MIN_LENGTH_RST;
      regs.max_length <= luhn_chk_pkg::MAX_LENGTH_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        luhn_chk_pkg::REG_MIN_LENGTH: regs.min_length <= cfg.data;
        luhn_chk_pkg::REG_MAX_LENGTH: regs.max_length <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/luhn_chk_acc.sv =====
module luhn_chk_acc (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic [luhn_chk_pkg::CHAR_W-1:0]     char_code,
  input  logic                                is_last,
  input  luhn_chk_pkg::cfg_t                  regs,
  output luhn_chk_pkg::acc_state_t            state,
  output luhn_chk_pkg::result_t               res
);

  luhn_chk_pkg::acc_state_t          state_next;
  logic                              is_digit;
  logic                              is_space;
  logic [luhn_chk_pkg::DIGIT_W-1:0]  d;
  logic [luhn_chk_pkg::DIGIT_W-1:0]  dd;
  logic [luhn_chk_pkg::DIGIT_W-1:0]  luhn_sum;

  // Classify the character; a digit's value is its low nibble
  assign is_digit = (char_code >= luhn_chk_pkg::CHAR_ZERO) &&
                    (char_code <= luhn_chk_pkg::CHAR_NINE);
  assign is_space = (char_code == luhn_chk_pkg::CHAR_SPACE) ||
                    ((char_code >= luhn_chk_pkg::CHAR_TAB) &&
                     (char_code <= luhn_chk_pkg::CHAR_CR));
  assign d  = char_code[luhn_chk_pkg::DIGIT_W-1:0];
  assign dd = luhn_chk_pkg::luhn_double(d);

  // Fold the character into the running sums and counters
  always_comb begin
    state_next = state;
    if (is_digit) begin
      if (state.cnt == '0) begin
        state_next.lead = d;
      end else if (state.cnt == luhn_chk_pkg::COUNT_W'(1)) begin
        state_next.second = d;
      end
      if (!state.parity) begin
        state_next.sum_even = luhn_chk_pkg::mod10_add(state.sum_even, dd);
        state_next.sum_odd  = luhn_chk_pkg::mod10_add(state.sum_odd, d);
      end else begin
        state_next.sum_even = luhn_chk_pkg::mod10_add(state.sum_even, d);
        state_next.sum_odd  = luhn_chk_pkg::mod10_add(state.sum_odd, dd);
      end
      state_next.parity = ~state.parity;
      if (state.cnt != luhn_chk_pkg::COUNT_MAX) begin
        state_next.cnt = luhn_chk_pkg::COUNT_W'(state.cnt + 1'b1);
      end
    end else if (!is_space) begin
      state_next.bad = 1'b1;
    end
  end

  // Status in priority order, issuer from the leading digits
  assign luhn_sum = state_next.parity ? state_next.sum_odd : state_next.sum_even;

  always_comb begin
    if (state_next.bad) begin
      res.status = luhn_chk_pkg::ST_BAD_CHAR;
    end else if ((state_next.cnt < regs.min_length) ||
                 (state_next.cnt > regs.max_length)) begin
      res.status = luhn_chk_pkg::ST_BAD_LENGTH;
    end else if (luhn_sum != '0) begin
      res.status = luhn_chk_pkg::ST_LUHN_FAIL;
    end else begin
      res.status = luhn_chk_pkg::ST_VALID;
    end

    if (state_next.cnt == '0) begin
      res.issuer = luhn_chk_pkg::ISS_OTHER;
    end else if (state_next.lead == luhn_chk_pkg::LEAD_AMEX_JCB) begin
      if ((state_next.cnt >= luhn_chk_pkg::COUNT_W'(2)) &&
          ((state_next.second == luhn_chk_pkg::AMEX_SECOND_A) ||
           (state_next.second == luhn_chk_pkg::AMEX_SECOND_B))) begin
        res.issuer = luhn_chk_pkg::ISS_AMEX;
      end else begin
        res.issuer = luhn_chk_pkg::ISS_JCB;
      end
    end else if (state_next.lead == luhn_chk_pkg::LEAD_VISA) begin
      res.issuer = luhn_chk_pkg::ISS_VISA;
    end else if (state_next.lead == luhn_chk_pkg::LEAD_MC) begin
      res.issuer = luhn_chk_pkg::ISS_MC;
    end else if (state_next.lead == luhn_chk_pkg::LEAD_MAESTRO) begin
      res.issuer = luhn_chk_pkg::ISS_MAESTRO;
    end else begin
      res.issuer = luhn_chk_pkg::ISS_OTHER;
    end

    res.digit_count = state_next.cnt;
  end

  // Advance the state; clear it after the last character of a number
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= is_last ? '0 : state_next;
    end
  end

endmodule
